// ===== design/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the lattice divergence block
// Field widths, command codes, axis codes and the accumulate-unit control word.
// ----------------------------------------------------------------------------
`default_nettype none

package lfd_pkg;

	localparam int NODES_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int IDX_W   = 10;   // node_index / queried_node
	localparam int NB_W    = 11;   // signed neighbour code, negative = none
	localparam int IN_W    = 32;   // value_x/y/z as carried on the bus
	localparam int OUT_W   = 36;   // divergence
	localparam int SPAN_W  = 17;   // wide enough to hold any node count
	localparam int ACC_GUARD = 5;  // accumulator headroom over a stored value

	localparam int S_TDATA_W = 176;
	localparam int M_TDATA_W = 48;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic MODE_2D = 1'b0;
	localparam logic MODE_3D = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic DIR_NEXT = 1'b0;
	localparam logic DIR_PREV = 1'b1;

	// control word of the shared accumulate unit: acc <= clr ? 0 : en ? acc +/- (val << sh) : acc
	typedef struct packed {
		logic       en;
		logic       clr;
		logic       neg;
		logic [1:0] sh;
	} lfd_alu_op_t;

endpackage

`default_nettype wire

// ===== design/lattice_fd_divergence.sv =====
// ----------------------------------------------------------------------------
// lattice_fd_divergence: finite-difference divergence over a stored lattice
// Load words write one node's components and neighbours; query words return
// the divergence at one node, with one-sided differences at boundaries.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents (low bit first)
//  s_*       in   tvalid/tready      tuser: command; tdata: node_index, value_x,
//                                    value_y, value_z, next_x, prev_x, next_y,
//                                    prev_y, next_z, prev_z, zero pad
//  m_*       out  tvalid/tready      tdata: queried_node, divergence, zero pad
//  cfg_*     in   cfg_we             cfg_wdata: lattice_mode
//
//  A load is the accept cycle followed by one neighbour-memory write per slot.
//  A query is accepted, walks each axis of the mode, then rounds and fills the
//  output register; each axis reads through the single read port of each memory
//  and uses one shared adder. An out-of-range node skips the axis walk.
//  s_tready is high only between items; a finished word sits in the output
//  register, so the next word is taken while it waits for m_tready.
//  Reset clears the sequencer, the output valid and lattice_mode; the stores
//  are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_fd_divergence #(
	parameter int NODES      = lfd_pkg::NODES_DEF,
	parameter int VALUE_BITS = lfd_pkg::VALUE_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// node_index, value_x, value_y, value_z, next_x, prev_x, next_y, prev_y,
	// next_z, prev_z, pad
	input  wire  [lfd_pkg::S_TDATA_W-1:0]    s_tdata,
	// command
	input  wire                              s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// queried_node, divergence, pad
	output logic [lfd_pkg::M_TDATA_W-1:0]    m_tdata,
	input  wire                              cfg_we,
	input  wire                              cfg_wdata
);

	localparam int AW    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CA_W  = $clog2(3 * NODES);
	localparam int NA_W  = $clog2(6 * NODES);
	localparam int ACC_W = VALUE_BITS + lfd_pkg::ACC_GUARD;
	localparam logic [lfd_pkg::SPAN_W-1:0] NODES_L = lfd_pkg::SPAN_W'(NODES);
	localparam logic [2:0] LD_COMP = 3'd3;
	localparam logic [2:0] LD_LAST = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_RD_N, S_RD_P, S_DEC, S_BOTH_P, S_BOTH_E,
		S_ONE_M, S_ONE_MM, S_ONE_F0, S_ONE_NP, S_RND, S_DONE
	} state_t;

	function automatic logic nb_ok(input logic [lfd_pkg::NB_W-1:0] code);
		nb_ok = !code[lfd_pkg::NB_W-1] &&
			(lfd_pkg::SPAN_W'(code[lfd_pkg::NB_W-2:0]) < NODES_L);
	endfunction

	// ---------------------------------------------------------------- fields
	logic [lfd_pkg::IDX_W-1:0]  in_node;
	logic [lfd_pkg::NB_W-1:0]   in_code [6];
	logic signed [lfd_pkg::IN_W-1:0] in_val [3];
	logic                       in_node_ok;
	logic                       s_acc;

	assign in_node   = s_tdata[9:0];
	assign in_val[0] = s_tdata[41:10];
	assign in_val[1] = s_tdata[73:42];
	assign in_val[2] = s_tdata[105:74];
	assign in_code[0] = s_tdata[116:106];
	assign in_code[1] = s_tdata[127:117];
	assign in_code[2] = s_tdata[138:128];
	assign in_code[3] = s_tdata[149:139];
	assign in_code[4] = s_tdata[160:150];
	assign in_code[5] = s_tdata[171:161];
	assign in_node_ok = lfd_pkg::SPAN_W'(in_node) < NODES_L;
	assign s_acc      = s_tvalid && s_tready;

	// ---------------------------------------------------------------- state
	state_t                        state_q;
	logic                          mode_q;
	logic [1:0]                    axis_q;
	logic [2:0]                    ld_cnt_q;
	logic                          out_valid_q;
	logic [lfd_pkg::IDX_W-1:0]     out_node_q;
	logic signed [lfd_pkg::OUT_W-1:0] out_div_q;

	// payload
	logic [lfd_pkg::IDX_W-1:0]     qidx_q;
	logic signed [VALUE_BITS-1:0]  ld_val_q [3];
	logic [lfd_pkg::NB_W-1:0]      ld_code_q [6];
	logic [lfd_pkg::NB_W-1:0]      n_q;
	logic [lfd_pkg::NB_W-1:0]      p_q;
	logic                          side_next_q;
	logic signed [VALUE_BITS-1:0]  f0_q;
	logic signed [VALUE_BITS-1:0]  fm_q;

	// memories and shared unit
	logic                          comp_we;
	logic [CA_W-1:0]               comp_waddr;
	logic signed [VALUE_BITS-1:0]  comp_wdata;
	logic [CA_W-1:0]               comp_raddr;
	logic signed [VALUE_BITS-1:0]  comp_rdata;
	logic                          nb_we;
	logic [NA_W-1:0]               nb_waddr;
	logic [lfd_pkg::NB_W-1:0]      nb_wdata;
	logic [NA_W-1:0]               nb_raddr;
	logic [lfd_pkg::NB_W-1:0]      nb_rdata;
	lfd_pkg::lfd_alu_op_t          alu_op;
	logic signed [VALUE_BITS-1:0]  alu_val;
	logic signed [ACC_W-1:0]       acc;
	logic signed [ACC_W-1:0]       half;

	logic [AW-1:0]                 node_a;
	logic [AW-1:0]                 ridx;
	logic [1:0]                    last_axis;
	logic                          axis_done;
	logic                          nv;
	logic                          pv;
	logic [lfd_pkg::NB_W-1:0]      m_code;
	state_t                        after_axis;

	assign node_a     = AW'(qidx_q);
	assign last_axis  = (mode_q == lfd_pkg::MODE_3D) ? lfd_pkg::AXIS_Z : lfd_pkg::AXIS_Y;
	assign axis_done  = (axis_q == last_axis);
	assign after_axis = axis_done ? S_RND : S_RD_N;
	assign nv         = nb_ok(n_q);
	assign pv         = nb_ok(nb_rdata);
	// one-sided: walk toward whichever neighbour exists; both: fetch next first
	assign m_code     = nv ? n_q : nb_rdata;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(lfd_pkg::M_TDATA_W - lfd_pkg::OUT_W - lfd_pkg::IDX_W){1'b0}},
		out_div_q, out_node_q};
	assign half     = acc >>> 1;

	// ------------------------------------------------------- load write path
	assign comp_we    = (state_q == S_LOAD) && (ld_cnt_q < LD_COMP);
	assign comp_waddr = (CA_W'(node_a) << 1) + CA_W'(node_a) + CA_W'(ld_cnt_q[1:0]);
	assign nb_we      = (state_q == S_LOAD);
	assign nb_waddr   = (NA_W'(node_a) << 2) + (NA_W'(node_a) << 1) + NA_W'(ld_cnt_q);

	always_comb begin
		comp_wdata = ld_val_q[0];
		case (ld_cnt_q[1:0])
			2'd1:    comp_wdata = ld_val_q[1];
			2'd2:    comp_wdata = ld_val_q[2];
			default: comp_wdata = ld_val_q[0];
		endcase
		nb_wdata = ld_code_q[0];
		case (ld_cnt_q)
			3'd1:    nb_wdata = ld_code_q[1];
			3'd2:    nb_wdata = ld_code_q[2];
			3'd3:    nb_wdata = ld_code_q[3];
			3'd4:    nb_wdata = ld_code_q[4];
			3'd5:    nb_wdata = ld_code_q[5];
			default: nb_wdata = ld_code_q[0];
		endcase
	end

	// ------------------------------------------------ read address and unit op
	logic rdir;

	always_comb begin
		ridx    = node_a;
		rdir    = lfd_pkg::DIR_NEXT;
		alu_op  = '0;
		alu_val = comp_rdata;
		case (state_q)
			S_IDLE: begin
				alu_op.clr = s_acc && (s_tuser == lfd_pkg::CMD_QUERY);
			end
			S_RD_N: begin
				rdir = lfd_pkg::DIR_NEXT;
			end
			S_RD_P: begin
				rdir = lfd_pkg::DIR_PREV;
			end
			S_DEC: begin
				ridx = AW'(m_code);
				rdir = nv ? lfd_pkg::DIR_NEXT : lfd_pkg::DIR_PREV;
				// one-sided: start with 2*f0
				alu_op.en  = nv != pv;
				alu_op.neg = nv;
				alu_op.sh  = 2'd1;
				alu_val    = f0_q;
			end
			S_BOTH_P: begin
				ridx      = AW'(p_q);
				alu_op.en = 1'b1;
			end
			S_BOTH_E: begin
				alu_op.en  = 1'b1;
				alu_op.neg = 1'b1;
			end
			S_ONE_M: begin
				ridx       = AW'(nb_rdata);
				alu_op.en  = 1'b1;
				alu_op.neg = !side_next_q;
				alu_op.sh  = 2'd2;
			end
			S_ONE_MM: begin
				alu_op.en  = 1'b1;
				alu_op.neg = side_next_q;
			end
			S_ONE_F0: begin
				alu_op.en  = 1'b1;
				alu_op.neg = side_next_q;
				alu_val    = f0_q;
			end
			S_ONE_NP: begin
				alu_op.en  = 1'b1;
				alu_op.neg = side_next_q;
				alu_op.sh  = 2'd1;
				alu_val    = fm_q;
			end
			S_RND: begin
				// round half up before the final halving
				alu_op.en = 1'b1;
				alu_val   = VALUE_BITS'(1);
			end
			default: begin
				ridx = node_a;
			end
		endcase
	end

	assign comp_raddr = (CA_W'(ridx) << 1) + CA_W'(ridx) + CA_W'(axis_q);
	assign nb_raddr   = (NA_W'(ridx) << 2) + (NA_W'(ridx) << 1) + NA_W'({axis_q, rdir});

	lfd_store #(
		.NODES      (NODES),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk        (clk),
		.comp_we    (comp_we),
		.comp_waddr (comp_waddr),
		.comp_wdata (comp_wdata),
		.comp_raddr (comp_raddr),
		.comp_rdata (comp_rdata),
		.nb_we      (nb_we),
		.nb_waddr   (nb_waddr),
		.nb_wdata   (nb_wdata),
		.nb_raddr   (nb_raddr),
		.nb_rdata   (nb_rdata)
	);

	lfd_alu #(
		.VALUE_BITS (VALUE_BITS)
	) u_alu (
		.clk (clk),
		.op  (alu_op),
		.val (alu_val),
		.acc (acc)
	);

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= lfd_pkg::MODE_2D;
			axis_q      <= lfd_pkg::AXIS_X;
			ld_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			out_node_q  <= '0;
			out_div_q   <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						ld_cnt_q <= '0;
						axis_q   <= lfd_pkg::AXIS_X;
						if (s_tuser == lfd_pkg::CMD_QUERY) begin
							state_q <= in_node_ok ? S_RD_N : S_RND;
						end else if (in_node_ok) begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					ld_cnt_q <= ld_cnt_q + 3'd1;
					if (ld_cnt_q == LD_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_RD_N: state_q <= S_RD_P;
				S_RD_P: state_q <= S_DEC;
				S_DEC: begin
					if (nv && pv) begin
						state_q <= S_BOTH_P;
					end else if (nv || pv) begin
						state_q <= S_ONE_M;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= after_axis;
					end
				end
				S_BOTH_P: state_q <= S_BOTH_E;
				S_ONE_M:  state_q <= nb_ok(nb_rdata) ? S_ONE_MM : S_ONE_NP;
				S_ONE_MM: state_q <= S_ONE_F0;
				S_BOTH_E, S_ONE_F0, S_ONE_NP: begin
					axis_q  <= axis_q + 2'd1;
					state_q <= after_axis;
				end
				S_RND: state_q <= S_DONE;
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_node_q  <= qidx_q;
						out_div_q   <= lfd_pkg::OUT_W'(half);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			qidx_q <= in_node;
			for (int k = 0; k < 3; k++) begin
				ld_val_q[k] <= VALUE_BITS'(in_val[k]);
			end
			for (int k = 0; k < 6; k++) begin
				ld_code_q[k] <= in_code[k];
			end
		end
		if (state_q == S_RD_P) begin
			n_q  <= nb_rdata;
			f0_q <= comp_rdata;
		end
		if (state_q == S_DEC) begin
			p_q         <= nb_rdata;
			side_next_q <= nv;
		end
		if (state_q == S_ONE_M) begin
			fm_q <= comp_rdata;
		end
	end

	// ------------------------------------------------------------ assertions
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD_N |-> axis_q <= last_axis)
		else $error("axis walk past the last axis of the mode");

	a_load_only_writes: assert property (@(posedge clk) disable iff (!arst_n)
		comp_we |-> state_q == S_LOAD && ld_cnt_q < LD_COMP)
		else $error("component write outside a load");

	a_oob_query: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tuser == lfd_pkg::CMD_QUERY && !in_node_ok |=> state_q == S_RND)
		else $error("out-of-range query did not skip the walk");

	a_oob_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tuser == lfd_pkg::CMD_LOAD && !in_node_ok |=> state_q == S_IDLE)
		else $error("out-of-range load was not dropped");

	a_done_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!out_valid_q || m_tready) |=> out_valid_q)
		else $error("finished query did not reach the output register");

endmodule

`default_nettype wire

// ===== design/lfd_store.sv =====
// ----------------------------------------------------------------------------
// lfd_store: component and neighbour memories
// Two simple dual-port arrays, one write and one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_store #(
	parameter int NODES      = lfd_pkg::NODES_DEF,
	parameter int VALUE_BITS = lfd_pkg::VALUE_BITS_DEF,
	localparam int CA_W = $clog2(3 * NODES),
	localparam int NA_W = $clog2(6 * NODES)
) (
	input  wire                               clk,
	input  wire                               comp_we,
	input  wire  [CA_W-1:0]                   comp_waddr,
	input  wire  signed [VALUE_BITS-1:0]      comp_wdata,
	input  wire  [CA_W-1:0]                   comp_raddr,
	output logic signed [VALUE_BITS-1:0]      comp_rdata,
	input  wire                               nb_we,
	input  wire  [NA_W-1:0]                   nb_waddr,
	input  wire  [lfd_pkg::NB_W-1:0]          nb_wdata,
	input  wire  [NA_W-1:0]                   nb_raddr,
	output logic [lfd_pkg::NB_W-1:0]          nb_rdata
);

	logic signed [VALUE_BITS-1:0]    comp_mem [3 * NODES];
	logic [lfd_pkg::NB_W-1:0]        nb_mem   [6 * NODES];

	always_ff @(posedge clk) begin
		if (comp_we) begin
			comp_mem[comp_waddr] <= comp_wdata;
		end
		comp_rdata <= comp_mem[comp_raddr];
	end

	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[nb_waddr] <= nb_wdata;
		end
		nb_rdata <= nb_mem[nb_raddr];
	end

endmodule

`default_nettype wire

// ===== design/lfd_alu.sv =====
// ----------------------------------------------------------------------------
// lfd_alu: shared shift-and-accumulate unit
// Adds or subtracts a stored value shifted by 0..3 into the divergence sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_alu #(
	parameter int VALUE_BITS = lfd_pkg::VALUE_BITS_DEF,
	localparam int ACC_W = VALUE_BITS + lfd_pkg::ACC_GUARD
) (
	input  wire                          clk,
	input  lfd_pkg::lfd_alu_op_t         op,
	input  wire  signed [VALUE_BITS-1:0] val,
	output logic signed [ACC_W-1:0]      acc
);

	logic signed [ACC_W-1:0] ext;
	logic signed [ACC_W-1:0] opnd;
	logic signed [ACC_W-1:0] acc_q;

	assign ext  = ACC_W'(val);
	assign opnd = ext <<< op.sh;
	assign acc  = acc_q;

	always_ff @(posedge clk) begin
		if (op.clr) begin
			acc_q <= '0;
		end else if (op.en) begin
			acc_q <= op.neg ? acc_q - opnd : acc_q + opnd;
		end
	end

endmodule

`default_nettype wire
